// ----- rtl/kinetic_min_heap_engine_macros.svh -----
// Assertion macros for the kinetic min-heap engine.
// Used by the engine top level; no other dependencies.
`ifndef KINETIC_MIN_HEAP_ENGINE_MACROS_SVH
`define KINETIC_MIN_HEAP_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define KHE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("khe assertion failed");
`define KHE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("khe assertion failed");
`else
`define KHE_ASSERT_IMP(lbl, ante, cons)
`define KHE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/khe_pkg.sv -----
// Shared types and constants for the kinetic min-heap engine.
// No dependencies.
package khe_pkg;

  localparam int CAPACITY  = 1024;
  localparam int POS_W     = $clog2(CAPACITY + 2);
  localparam int RAM_DEPTH = CAPACITY + 1;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int COUNT_W   = 11;
  localparam int NUM_W     = 49;
  localparam int DIV_STEPS = NUM_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_QUERY   = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [31:0] intercept;
    logic signed [31:0] slope;
    logic [15:0]        id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [4:0] {
    S_IDLE,
    S_INS_K1, S_INS_K2, S_INS_CHK, S_INS_RD, S_INS_K3,
    S_ADV_NEXT, S_ADV_RD, S_ADV_K,
    S_DN_CHK, S_DN_LRD, S_DN_LK, S_DN_RRD, S_DN_RK, S_DN_DEC,
    S_Q_NEXT, S_Q_PRD, S_Q_JCHK, S_Q_CRD, S_Q_DIV, S_Q_FIN,
    S_DONE
  } state_t;

endpackage

// ----- rtl/khe_ram.sv -----
// Generic simple dual-port RAM with registered read.
// No dependencies.
module khe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/kinetic_min_heap_engine.sv -----
// Kinetic min-heap engine top level: sequencer, key datapath, divider.
// Depends on khe_pkg, khe_ram and kinetic_min_heap_engine_macros.svh.
//
// One transaction is taken at a time (in_stall is high while an operation
// runs) and gives one result. Entries live in one RAM (one read, one write per
// cycle, read data registered); each fetched entry's key is formed by one
// 32x32 multiply, whose product is registered, and one 64-bit add. Insert
// forms the new key, then walks up one level at a time (levels up to
// log2(count)), reading the parent and comparing keys. Advance sifts down
// every position from count/2 to 1. Next-event visits every parent-child
// pair and runs a 49-step restoring divider for each pair with different
// slopes. The divider sets the query time; the RAM port and the multiplier
// set the rest. A finished result waits in the output register while the
// next transaction is already accepted. Keys are compared exactly in Q32.32;
// crossing times are truncated toward zero and saturated to 32 bits.
`include "kinetic_min_heap_engine_macros.svh"
module kinetic_min_heap_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          opcode,
  input  logic signed [31:0]  line_intercept,
  input  logic signed [31:0]  line_slope,
  input  logic [15:0]         entry_id,
  input  logic signed [31:0]  new_time,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                status,
  output logic                event_found,
  output logic signed [31:0]  event_time,
  output logic [10:0]         entry_count
);

  khe_pkg::state_t state, state_next;

  logic [khe_pkg::POS_W-1:0] cnt, p, s, i, best_pos;
  logic [khe_pkg::POS_W:0]   j;
  logic signed [31:0]        cur_time, best_q;
  khe_pkg::entry_t           cur, oth, par, best_ent, rd;
  logic signed [63:0]        prod, cur_key, best_key, key_sum;
  logic                      rej, found;

  // divider state
  logic [33:0]                 dv_rem;
  logic [khe_pkg::NUM_W-1:0]   dv_q;
  logic [32:0]                 dv_d;
  logic                        dv_neg;
  logic [khe_pkg::DCNT_W-1:0]  dv_cnt;

  // RAM port
  logic                       ram_we;
  logic [khe_pkg::POS_W-1:0]  ram_waddr, ram_raddr;
  khe_pkg::entry_t            ram_wdata;
  logic [khe_pkg::ENTRY_W-1:0] ram_rdata;

  khe_ram #(
    .WIDTH(khe_pkg::ENTRY_W),
    .DEPTH(khe_pkg::RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr[khe_pkg::RAM_AW-1:0]),
    .wdata(ram_wdata),
    .raddr(ram_raddr[khe_pkg::RAM_AW-1:0]),
    .rdata(ram_rdata)
  );

  assign rd = khe_pkg::entry_t'(ram_rdata);

  // child positions of p and i, and the widened count, one bit wider than a position
  logic [khe_pkg::POS_W:0] lpos, rpos, cnt_x, iodd;
  assign lpos  = {p, 1'b0};
  assign rpos  = {p, 1'b1};
  assign cnt_x = {1'b0, cnt};
  assign iodd  = {i, 1'b1};

  // key datapath: product registered, then one add
  logic signed [31:0] mul_slope, key_a;
  assign mul_slope = (state == khe_pkg::S_INS_K1) ? cur.slope : rd.slope;
  assign key_a = (state == khe_pkg::S_INS_K2 || state == khe_pkg::S_ADV_K) ?
                 cur.intercept : oth.intercept;
  assign key_sum = $signed({{16{key_a[31]}}, key_a, 16'h0000}) + prod;

  logic key_lt_best;
  assign key_lt_best = key_sum < best_key;

  // pair setup for the divider
  logic signed [32:0] den, ndiff;
  logic [32:0]        den_mag, ndiff_mag;
  assign den       = {par.slope[31], par.slope} - {rd.slope[31], rd.slope};
  assign ndiff     = {rd.intercept[31], rd.intercept} - {par.intercept[31], par.intercept};
  assign den_mag   = den[32] ? 33'(-den) : 33'(den);
  assign ndiff_mag = ndiff[32] ? 33'(-ndiff) : 33'(ndiff);

  // one restoring step
  logic [34:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {dv_rem, dv_q[khe_pkg::NUM_W-1]};
  assign rem_ge = rem_sh >= {2'b00, dv_d};

  // final quotient: sign, saturate
  logic signed [khe_pkg::NUM_W:0] q_s;
  logic signed [31:0]             q_sat;
  assign q_s = dv_neg ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q});
  always_comb begin
    if (q_s > $signed(50'sd2147483647)) begin
      q_sat = 32'sh7fffffff;
    end else if (q_s < -$signed(50'sd2147483648)) begin
      q_sat = 32'sh80000000;
    end else begin
      q_sat = q_s[31:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != khe_pkg::S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      khe_pkg::S_IDLE: begin
        if (in_valid) begin
          case (khe_pkg::op_t'(opcode))
            khe_pkg::OP_INSERT:
              state_next = (cnt >= khe_pkg::POS_W'(khe_pkg::CAPACITY)) ?
                           khe_pkg::S_DONE : khe_pkg::S_INS_K1;
            khe_pkg::OP_ADVANCE: state_next = khe_pkg::S_ADV_NEXT;
            khe_pkg::OP_QUERY:   state_next = khe_pkg::S_Q_NEXT;
            default:             state_next = khe_pkg::S_DONE;
          endcase
        end
      end
      khe_pkg::S_INS_K1:  state_next = khe_pkg::S_INS_K2;
      khe_pkg::S_INS_K2:  state_next = khe_pkg::S_INS_CHK;
      khe_pkg::S_INS_CHK:
        state_next = (p > khe_pkg::POS_W'(1)) ? khe_pkg::S_INS_RD : khe_pkg::S_DONE;
      khe_pkg::S_INS_RD:  state_next = khe_pkg::S_INS_K3;
      khe_pkg::S_INS_K3:
        state_next = (cur_key < key_sum) ? khe_pkg::S_INS_CHK : khe_pkg::S_DONE;
      khe_pkg::S_ADV_NEXT:
        state_next = (s == '0) ? khe_pkg::S_DONE : khe_pkg::S_ADV_RD;
      khe_pkg::S_ADV_RD:  state_next = khe_pkg::S_ADV_K;
      khe_pkg::S_ADV_K:   state_next = khe_pkg::S_DN_CHK;
      khe_pkg::S_DN_CHK:
        state_next = (lpos > cnt_x) ? khe_pkg::S_ADV_NEXT : khe_pkg::S_DN_LRD;
      khe_pkg::S_DN_LRD:  state_next = khe_pkg::S_DN_LK;
      khe_pkg::S_DN_LK:
        state_next = (rpos > cnt_x) ? khe_pkg::S_DN_DEC : khe_pkg::S_DN_RRD;
      khe_pkg::S_DN_RRD:  state_next = khe_pkg::S_DN_RK;
      khe_pkg::S_DN_RK:   state_next = khe_pkg::S_DN_DEC;
      khe_pkg::S_DN_DEC:
        state_next = (best_pos == p) ? khe_pkg::S_ADV_NEXT : khe_pkg::S_DN_CHK;
      khe_pkg::S_Q_NEXT:
        state_next = (i > cnt) ? khe_pkg::S_DONE : khe_pkg::S_Q_PRD;
      khe_pkg::S_Q_PRD:   state_next = khe_pkg::S_Q_JCHK;
      khe_pkg::S_Q_JCHK:
        state_next = (j > cnt_x || j > iodd) ? khe_pkg::S_Q_NEXT : khe_pkg::S_Q_CRD;
      khe_pkg::S_Q_CRD:
        state_next = (den == '0) ? khe_pkg::S_Q_JCHK : khe_pkg::S_Q_DIV;
      khe_pkg::S_Q_DIV:
        state_next = (dv_cnt == khe_pkg::DCNT_W'(khe_pkg::DIV_STEPS - 1)) ?
                     khe_pkg::S_Q_FIN : khe_pkg::S_Q_DIV;
      khe_pkg::S_Q_FIN:   state_next = khe_pkg::S_Q_JCHK;
      khe_pkg::S_DONE:
        state_next = out_free ? khe_pkg::S_IDLE : khe_pkg::S_DONE;
      default:            state_next = khe_pkg::S_IDLE;
    endcase
  end

  // RAM controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p;
    ram_wdata = cur;
    ram_raddr = '0;
    case (state)
      khe_pkg::S_INS_CHK: begin
        if (p > khe_pkg::POS_W'(1)) begin
          ram_raddr = p >> 1;
        end else begin
          ram_we = 1'b1;
        end
      end
      khe_pkg::S_INS_K3: begin
        ram_we = 1'b1;
        if (cur_key < key_sum) begin
          ram_wdata = oth;
        end
      end
      khe_pkg::S_ADV_NEXT: ram_raddr = s;
      khe_pkg::S_DN_CHK: begin
        if (lpos > cnt_x) begin
          ram_we = 1'b1;
        end else begin
          ram_raddr = lpos[khe_pkg::POS_W-1:0];
        end
      end
      khe_pkg::S_DN_LK:  ram_raddr = rpos[khe_pkg::POS_W-1:0];
      khe_pkg::S_DN_DEC: begin
        ram_we = 1'b1;
        if (best_pos != p) begin
          ram_wdata = best_ent;
        end
      end
      khe_pkg::S_Q_NEXT: ram_raddr = i;
      khe_pkg::S_Q_JCHK: ram_raddr = j[khe_pkg::POS_W-1:0];
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= khe_pkg::S_IDLE;
      cnt       <= '0;
      cur_time  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == khe_pkg::S_IDLE && in_valid) begin
        if (khe_pkg::op_t'(opcode) == khe_pkg::OP_INSERT &&
            cnt < khe_pkg::POS_W'(khe_pkg::CAPACITY)) begin
          cnt <= cnt + 1'b1;
        end
        if (khe_pkg::op_t'(opcode) == khe_pkg::OP_ADVANCE) begin
          cur_time <= new_time;
        end
      end
      if (state == khe_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_slope * cur_time;
    case (state)
      khe_pkg::S_IDLE: begin
        rej    <= (khe_pkg::op_t'(opcode) == khe_pkg::OP_INSERT) &&
                  (cnt >= khe_pkg::POS_W'(khe_pkg::CAPACITY));
        found  <= 1'b0;
        best_q <= '0;
        cur    <= '{intercept: line_intercept, slope: line_slope, id: entry_id};
        p      <= cnt + 1'b1;
        s      <= cnt >> 1;
        i      <= khe_pkg::POS_W'(1);
      end
      khe_pkg::S_INS_K2: cur_key <= key_sum;
      khe_pkg::S_INS_RD: oth <= rd;
      khe_pkg::S_INS_K3: begin
        if (cur_key < key_sum) begin
          p <= p >> 1;
        end
      end
      khe_pkg::S_ADV_NEXT: p <= s;
      khe_pkg::S_ADV_RD:   cur <= rd;
      khe_pkg::S_ADV_K:    cur_key <= key_sum;
      khe_pkg::S_DN_CHK: begin
        best_pos <= p;
        best_key <= cur_key;
        if (lpos > cnt_x) begin
          s <= s - 1'b1;
        end
      end
      khe_pkg::S_DN_LRD, khe_pkg::S_DN_RRD: oth <= rd;
      khe_pkg::S_DN_LK: begin
        if (key_lt_best) begin
          best_key <= key_sum;
          best_pos <= lpos[khe_pkg::POS_W-1:0];
          best_ent <= oth;
        end
      end
      khe_pkg::S_DN_RK: begin
        if (key_lt_best) begin
          best_key <= key_sum;
          best_pos <= rpos[khe_pkg::POS_W-1:0];
          best_ent <= oth;
        end
      end
      khe_pkg::S_DN_DEC: begin
        if (best_pos == p) begin
          s <= s - 1'b1;
        end else begin
          p <= best_pos;
        end
      end
      khe_pkg::S_Q_NEXT: j <= {i, 1'b0};
      khe_pkg::S_Q_PRD:  par <= rd;
      khe_pkg::S_Q_JCHK: begin
        if (j > cnt_x || j > iodd) begin
          i <= i + 1'b1;
        end
      end
      khe_pkg::S_Q_CRD: begin
        dv_d   <= den_mag;
        dv_q   <= {ndiff_mag, 16'h0000};
        dv_rem <= '0;
        dv_neg <= ndiff[32] ^ den[32];
        dv_cnt <= '0;
        if (den == '0) begin
          j <= j + 1'b1;
        end
      end
      khe_pkg::S_Q_DIV: begin
        dv_cnt <= dv_cnt + 1'b1;
        if (rem_ge) begin
          dv_rem <= 34'(rem_sh - {2'b00, dv_d});
        end else begin
          dv_rem <= rem_sh[33:0];
        end
        dv_q <= {dv_q[khe_pkg::NUM_W-2:0], rem_ge};
      end
      khe_pkg::S_Q_FIN: begin
        j <= j + 1'b1;
        if (q_sat > cur_time && (!found || q_sat < best_q)) begin
          found  <= 1'b1;
          best_q <= q_sat;
        end
      end
      khe_pkg::S_DONE: begin
        if (out_free) begin
          status      <= rej;
          event_found <= found;
          event_time  <= best_q;
          entry_count <= khe_pkg::COUNT_W'(cnt);
        end
      end
      default: ;
    endcase
  end

  `KHE_ASSERT_IMP(a_count_in_range, 1'b1, cnt <= khe_pkg::CAPACITY)
  `KHE_ASSERT_IMP(a_no_time_without_event, out_valid && !event_found, event_time == 0)
  `KHE_ASSERT_IMP(a_reject_only_full, out_valid && status, entry_count == khe_pkg::CAPACITY)
  `KHE_ASSERT_NXT(a_insert_grows, in_valid && !in_stall && opcode == khe_pkg::OP_INSERT && cnt < khe_pkg::CAPACITY, cnt == $past(cnt) + 1)

endmodule

// ----- tb/tb_kinetic_min_heap_engine.sv -----
// Self-checking testbench for the kinetic min-heap engine: directed table, then random traffic.
// Depends on khe_pkg and the kinetic_min_heap_engine RTL; predictor is internal.
module tb_kinetic_min_heap_engine;

  localparam int N_RANDOM = 122;
  localparam longint CYCLE_LIMIT = 64'd4000000;

  typedef struct packed {
    logic        status;
    logic        event_found;
    logic [31:0] event_time;
    logic [10:0] entry_count;
  } result_t;

  typedef struct {
    khe_pkg::op_t op;
    logic [31:0] icpt;
    logic [31:0] slp;
    logic [15:0] id;
    logic [31:0] tm;
    bit          typed;   // expected result written into the table
    result_t     res;
  } stim_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [1:0] opcode;
  logic signed [31:0] line_intercept, line_slope, new_time;
  logic [15:0] entry_id;
  logic out_valid, out_stall;
  logic status, event_found;
  logic signed [31:0] event_time;
  logic [10:0] entry_count;

  kinetic_min_heap_engine dut (.*);

  // Shadow heap kept by the predictor
  logic signed [31:0] sh_icpt [1:khe_pkg::CAPACITY];
  logic signed [31:0] sh_slp  [1:khe_pkg::CAPACITY];
  logic [15:0]        sh_id   [1:khe_pkg::CAPACITY];
  int                 sh_count;
  logic signed [31:0] sh_now;

  result_t pending_results[$];
  int  errors = 0;
  int  n_checked = 0;
  int  n_events = 0;
  bit  quiet = 0;   // last part of the run: no idling on either side
  longint cycles = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Limit the run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout at %0t after %0d cycles", $time, cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint heap_key(int p);
    return longint'(sh_icpt[p]) * 65536 + longint'(sh_slp[p]) * longint'(sh_now);
  endfunction

  function automatic void swap_entries(int p, int q);
    logic signed [31:0] a, b;
    logic [15:0] d;
    a = sh_icpt[p]; b = sh_slp[p]; d = sh_id[p];
    sh_icpt[p] = sh_icpt[q]; sh_slp[p] = sh_slp[q]; sh_id[p] = sh_id[q];
    sh_icpt[q] = a; sh_slp[q] = b; sh_id[q] = d;
  endfunction

  function automatic void sift_down(int p);
    int best, l, r;
    forever begin
      best = p; l = 2 * p; r = 2 * p + 1;
      if (l <= sh_count && heap_key(l) < heap_key(best)) best = l;
      if (r <= sh_count && heap_key(r) < heap_key(best)) best = r;
      if (best == p) break;
      swap_entries(p, best);
      p = best;
    end
  endfunction

  // Compute the result of one operation and update the shadow heap
  function automatic result_t predict_heap_op(stim_t s);
    result_t r;
    int p;
    longint den, num, q, bestq;
    r = '{1'b0, 1'b0, 32'd0, 11'd0};
    case (s.op)
      khe_pkg::OP_INSERT: begin
        if (sh_count >= khe_pkg::CAPACITY) r.status = 1'b1;
        else begin
          sh_count++;
          sh_icpt[sh_count] = s.icpt;
          sh_slp[sh_count] = s.slp;
          sh_id[sh_count] = s.id;
          p = sh_count;
          while (p > 1 && heap_key(p) < heap_key(p / 2)) begin
            swap_entries(p, p / 2);
            p = p / 2;
          end
        end
      end
      khe_pkg::OP_ADVANCE: begin
        sh_now = s.tm;
        for (p = sh_count / 2; p >= 1; p--) sift_down(p);
      end
      khe_pkg::OP_QUERY: begin
        bestq = 0;
        for (int i = 1; i <= sh_count; i++)
          for (int j = 2 * i; j <= 2 * i + 1 && j <= sh_count; j++) begin
            den = longint'(sh_slp[i]) - longint'(sh_slp[j]);
            if (den == 0) continue;   // parallel lines never cross
            num = (longint'(sh_icpt[j]) - longint'(sh_icpt[i])) * 65536;
            q = num / den;
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            if (q > longint'(sh_now) && (!r.event_found || q < bestq)) begin
              bestq = q;
              r.event_found = 1'b1;
            end
          end
        r.event_time = r.event_found ? bestq[31:0] : 32'd0;
      end
      default: ;
    endcase
    r.entry_count = sh_count[10:0];
    return r;
  endfunction

  // Present one transaction and hold it until accepted; then idle now and then
  task automatic send_op(stim_t s);
    result_t r;
    r = predict_heap_op(s);
    if (s.typed && r != s.res) begin
      $display("%0t: table entry disagrees with predictor for op %s", $time, s.op.name());
      errors++;
    end
    pending_results.push_back(s.typed ? s.res : r);
    in_valid <= 1'b1;
    opcode <= s.op;
    line_intercept <= s.icpt;
    line_slope <= s.slp;
    entry_id <= s.id;
    new_time <= s.tm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  // Receiver: stall in random bursts, check each accepted result
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0b found=%0b time=%0d count=%0d",
                 $time, status, event_found, event_time, entry_count);
        errors++;
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (event_found) n_events++;
        if (status !== e.status) begin
          $display("%0t: status expected %0b actual %0b", $time, e.status, status);
          errors++;
        end
        if (event_found !== e.event_found) begin
          $display("%0t: event_found expected %0b actual %0b", $time, e.event_found,
                   event_found);
          errors++;
        end
        if (event_time !== e.event_time) begin
          $display("%0t: event_time expected %0d actual %0d", $time,
                   $signed(e.event_time), event_time);
          errors++;
        end
        if (entry_count !== e.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, e.entry_count,
                   entry_count);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
  endfunction

  function automatic stim_t make_op(khe_pkg::op_t op, logic [31:0] a, logic [31:0] b,
                                    logic [15:0] id, logic [31:0] t);
    stim_t s;
    s.op = op; s.icpt = a; s.slp = b; s.id = id; s.tm = t; s.typed = 0;
    s.res = '{1'b0, 1'b0, 32'd0, 11'd0};
    return s;
  endfunction

  stim_t table_rows[$];

  initial begin
    stim_t s;
    int k;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = khe_pkg::OP_NOP;
    line_intercept = '0;
    line_slope = '0;
    entry_id = '0;
    new_time = '0;
    sh_count = 0;
    sh_now = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table; typed rows are readable straight off the spec
    s = make_op(khe_pkg::OP_QUERY, 0, 0, 16'h0000, 0); s.typed = 1;  // empty heap
    table_rows.push_back(s);
    s = make_op(khe_pkg::OP_NOP, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
    s.typed = 1; table_rows.push_back(s);                              // unused opcode
    s = make_op(khe_pkg::OP_ADVANCE, 0, 0, 16'h0000, 32'h8000_0000);   // advance, empty
    s.typed = 1; table_rows.push_back(s);
    table_rows.push_back(make_op(khe_pkg::OP_INSERT, 32'h7fff_ffff, 32'h8000_0000,
                                 16'hffff, 0));
    table_rows.push_back(make_op(khe_pkg::OP_INSERT, 32'h8000_0000, 32'h7fff_ffff,
                                 16'h0000, 0));
    table_rows.push_back(make_op(khe_pkg::OP_QUERY, 0, 0, 16'h0000, 0));  // extreme values
    table_rows.push_back(make_op(khe_pkg::OP_INSERT, 32'h0001_0000, 32'h0001_0000,
                                 16'h1234, 0));
    table_rows.push_back(make_op(khe_pkg::OP_INSERT, 32'h0002_0000, 32'h0001_0000,
                                 16'h4321, 0));
    table_rows.push_back(make_op(khe_pkg::OP_QUERY, 0, 0, 16'h0000, 0));  // equal slopes
    table_rows.push_back(make_op(khe_pkg::OP_ADVANCE, 0, 0, 16'h0000, 32'h7fff_ffff));
    table_rows.push_back(make_op(khe_pkg::OP_QUERY, 0, 0, 16'h0000, 0));  // after max time
    table_rows.push_back(make_op(khe_pkg::OP_ADVANCE, 0, 0, 16'h0000, 32'h0000_8000));
    table_rows.push_back(make_op(khe_pkg::OP_INSERT, 32'hfffe_0000, 32'h0003_0000,
                                 16'h00aa, 0));
    table_rows.push_back(make_op(khe_pkg::OP_QUERY, 0, 0, 16'h0000, 0));
    table_rows.push_back(make_op(khe_pkg::OP_ADVANCE, 0, 0, 16'h0000, 32'hfff0_0000));
    table_rows.push_back(make_op(khe_pkg::OP_QUERY, 0, 0, 16'h0000, 0));
    foreach (table_rows[i]) send_op(table_rows[i]);

    // Random traffic: mostly inserts and advances on a growing heap
    for (k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM - 30) quiet = 1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: s = make_op(khe_pkg::OP_INSERT, rand_value(), rand_value(),
                                   16'($urandom), 0);
        5, 6: s = make_op(khe_pkg::OP_ADVANCE, $urandom, $urandom, 16'($urandom),
                          rand_value());
        7, 8: s = make_op(khe_pkg::OP_QUERY, $urandom, $urandom, 16'($urandom),
                          $urandom);
        default: s = make_op(khe_pkg::op_t'(2'($urandom)), $urandom, $urandom,
                             16'($urandom), rand_value());
      endcase
      send_op(s);
    end

    // Rebuild the grown heap once more and ask for its next crossing
    send_op(make_op(khe_pkg::OP_ADVANCE, 0, 0, 16'h0000, rand_value()));
    send_op(make_op(khe_pkg::OP_QUERY, 0, 0, 16'h0000, 0));
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Checked %0d results (%0d with a crossing event) over directed and random ops",
             n_checked, n_events);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
